/* hdl/smm_pkg.sv */
// Package for the matrix multiplier: sizes, widths and shared types.
// Used by every module under hdl; depends on nothing.
package smm_pkg;
	localparam int MaxDim = 8;
	localparam int ElemBits = 16;
	localparam int Cells = MaxDim * MaxDim;
	localparam int AddrBits = $clog2(Cells);
	localparam int DimBits = $clog2(MaxDim);
	localparam int ProdBits = 35;
	localparam int AccBits = 40;

	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [DimBits-1:0] dim_idx_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic enable;
	} mac_ctrl_t;
endpackage

/* hdl/smm_mac.sv */
// Shared multiply-accumulate unit for the matrix multiplier.
// Depends on smm_pkg.
module smm_mac (
	input logic clk,
	input smm_pkg::mac_ctrl_t ctrl,
	input logic signed [smm_pkg::ElemBits-1:0] left,
	input logic signed [smm_pkg::ElemBits-1:0] right,
	output logic signed [smm_pkg::AccBits-1:0] acc
);
	import smm_pkg::*;

	logic signed [2*ElemBits-1:0] prod_q;
	logic signed [AccBits-1:0] acc_q;

	// Product register, then accumulate; clear restarts a new dot product.
	always_ff @(posedge clk) begin
		prod_q <= left * right;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.enable) begin
			acc_q <= acc_q + AccBits'(prod_q);
		end
	end

	assign acc = acc_q;
endmodule

/* hdl/strassen_matrix_multiply.sv */
// Top level of the matrix multiplier: load stores, sequencer and output.
// Depends on smm_pkg and smm_mac.
//
// Usage: set size_log2 through cfg_valid/cfg_ready/cfg_data (n = 2**size_log2);
// a write drops any partly loaded matrix and holds off the input in its cycle.
// Each input transfer on in_valid/in_stall carries one A and one B element in
// row-major order. After the n*n-th transfer the block computes C = A*B
// exactly and emits n*n result transfers in row-major order on
// out_valid/out_stall, with last_of_run high on the final one. Each element is
// a dot product on one shared multiplier and accumulator: multiply-accumulate in
// ST_MAC, the result registered to the output in ST_OUT, and a wait in ST_WAIT
// until it is taken. The input stalls during compute and output. A stalled
// result holds in its register and the sequencer waits. Reset sets n to 8 and
// clears the load count; the stores need no reset.
module strassen_matrix_multiply (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] a_element,
	input logic signed [15:0] b_element,
	output logic out_valid,
	input logic out_stall,
	output logic signed [34:0] product_element,
	output logic [2:0] row_index,
	output logic [2:0] column_index,
	output logic last_of_run
);
	import smm_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_MAC  = 4'b0010,
		ST_OUT  = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] size_q;
	logic [AddrBits:0] load_q;
	dim_idx_t row_q, col_q, k_q;
	logic [3:0] step_q;
	logic signed [ElemBits-1:0] left_mem [Cells];
	logic signed [ElemBits-1:0] right_mem [Cells];
	logic signed [ElemBits-1:0] left_rd_q, right_rd_q;
	logic signed [AccBits-1:0] acc;
	mac_ctrl_t mac_ctrl;
	logic in_fire, out_fire;
	logic [AddrBits:0] total;
	dim_idx_t dmax;
	logic [3:0] last_step;
	logic [AddrBits-1:0] ra, rb;

	assign total = (AddrBits+1)'(1) << (2 * size_q);
	assign dmax = dim_idx_t'(((DimBits+1)'(1) << size_q) - 1'b1);
	assign cfg_ready = state_q == ST_LOAD;
	// A configuration write takes the cycle, so the input waits.
	assign in_stall = state_q != ST_LOAD || cfg_valid;
	assign in_fire = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	// Element index i*n+k is i shifted by log2(n) plus k.
	assign ra = AddrBits'(({3'b0, row_q} << size_q) | AddrBits'(k_q));
	assign rb = AddrBits'(({3'b0, k_q} << size_q) | AddrBits'(col_q));
	// After the last k is issued, its operand pair still passes the read registers
	// and the product register before the accumulator takes it.
	assign last_step = 4'(dmax) + 4'd2;

	// Operand stores, one write port and one registered read each.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_mem[load_q[AddrBits-1:0]] <= a_element;
			right_mem[load_q[AddrBits-1:0]] <= b_element;
		end
		left_rd_q <= left_mem[ra];
		right_rd_q <= right_mem[rb];
	end

	always_comb begin
		mac_ctrl.clear = state_q != ST_MAC;
		mac_ctrl.enable = state_q == ST_MAC && step_q >= 4'd2;
	end

	smm_mac u_mac (
		.clk(clk), .ctrl(mac_ctrl), .left(left_rd_q), .right(right_rd_q), .acc(acc)
	);

	// Sequencer: load, one dot product per element, hand off to output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= 2'd3;
			load_q <= '0;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			step_q <= '0;
			out_valid <= 1'b0;
			product_element <= '0;
			row_index <= '0;
			column_index <= '0;
			last_of_run <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_valid) begin
						size_q <= cfg_data;
						load_q <= '0;
					end else if (in_fire) begin
						if (load_q + 1'b1 == total) begin
							load_q <= '0;
							state_q <= ST_MAC;
							row_q <= '0;
							col_q <= '0;
							k_q <= '0;
							step_q <= '0;
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
				end
				ST_MAC: begin
					if (k_q != dmax) begin
						k_q <= k_q + 1'b1;
					end
					if (step_q == last_step) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					product_element <= acc[ProdBits-1:0];
					row_index <= 3'(row_q);
					column_index <= 3'(col_q);
					last_of_run <= row_q == dmax && col_q == dmax;
					out_valid <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_fire) begin
						out_valid <= 1'b0;
						k_q <= '0;
						step_q <= '0;
						if (col_q != dmax) begin
							col_q <= col_q + 1'b1;
							state_q <= ST_MAC;
						end else if (row_q != dmax) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

/* dv/tb.sv */
// Self-checking testbench for the matrix multiplier strassen_matrix_multiply.
// Drives element pairs and size settings, predicts each product matrix with a
// plain dot-product model and checks every result transfer; depends on smm_pkg and the DUT.
`timescale 1ns / 1ps

module tb;
	import smm_pkg::*;

	localparam int TimeoutCycles = 1500000;

	typedef struct packed {
		logic signed [34:0] product;
		logic [2:0] row;
		logic [2:0] col;
		logic last;
	} product_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] a_element;
	logic signed [15:0] b_element;
	logic out_valid;
	logic out_stall;
	logic signed [34:0] product_element;
	logic [2:0] row_index;
	logic [2:0] column_index;
	logic last_of_run;

	// Predictor state: current size and the partly loaded matrices.
	int dim_log2;
	int loaded;
	logic signed [15:0] a_mat [Cells];
	logic signed [15:0] b_mat [Cells];
	product_t expected_products [$];

	int mismatches;
	int checked;
	int cycles;
	int matrices;
	bit idle_enable;
	bit hold_off;

	strassen_matrix_multiply dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_element(a_element), .b_element(b_element),
		.out_valid(out_valid), .out_stall(out_stall),
		.product_element(product_element), .row_index(row_index),
		.column_index(column_index), .last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter with a hard limit on the run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > TimeoutCycles) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Computes the product matrix once the last pair is in.
	task automatic compute_product();
		int n;
		logic signed [63:0] acc;
		product_t item;
		n = 1 << dim_log2;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += 64'(a_mat[r * n + k]) * 64'(b_mat[k * n + c]);
				item.product = acc[34:0];
				item.row = 3'(r);
				item.col = 3'(c);
				item.last = (r == n - 1) && (c == n - 1);
				expected_products.push_back(item);
			end
		end
		matrices++;
	endtask

	// Sends one element pair; the prediction is updated on the transfer.
	// Valid stays high after the transfer so pairs can follow back to back.
	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b);
		int n;
		while (idle_enable && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		a_element <= a;
		b_element <= b;
		do @(posedge clk); while (in_stall);
		n = 1 << dim_log2;
		a_mat[loaded] = a;
		b_mat[loaded] = b;
		loaded++;
		if (loaded == n * n) begin
			compute_product();
			loaded = 0;
		end
		@(negedge clk);
	endtask

	// Waits for all results, then lets the block settle and writes the size.
	task automatic write_size(input int value);
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 2'(value);
		do @(posedge clk); while (!cfg_ready);
		dim_log2 = value;
		loaded = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_element();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, long hold-off on request, checks each transfer.
	initial begin
		product_t want;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			out_stall <= idle_enable && ($urandom_range(99) < 28);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_products.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result transfer: %0d", product_element);
				end else begin
					want = expected_products.pop_front();
					checked++;
					if (want.product !== product_element || want.row !== row_index ||
							want.col !== column_index || want.last !== last_of_run) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
								want.product, want.row, want.col, want.last,
								product_element, row_index, column_index, last_of_run);
					end
				end
			end
		end
	end

	// Extreme values at size one and two: negative by negative, positive by negative, positive by positive.
	task automatic test_directed_small();
		write_size(0);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh0000, 16'shffff);
		write_size(1);
		for (int i = 0; i < 4; i++)
			send_pair(16'sh8000, 16'sh8000);
		for (int i = 0; i < 4; i++)
			send_pair(16'sh7fff, 16'sh8000);
	endtask

	// Full size from reset with the most negative value everywhere, which gives the widest products.
	// Neither side idles here, which gives the long stretch without gaps.
	task automatic test_directed_max();
		write_size(3);
		idle_enable = 1'b0;
		for (int i = 0; i < 64; i++)
			send_pair(16'sh8000, 16'sh8000);
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(negedge clk);
		idle_enable = 1'b1;
	endtask

	// A size write in the middle of a load drops the partial matrix.
	task automatic test_partial_drop();
		write_size(2);
		for (int i = 0; i < 5; i++)
			send_pair(rand_element(), rand_element());
		write_size(2);
		for (int i = 0; i < 16; i++)
			send_pair(rand_element(), rand_element());
	endtask

	// Long receiver hold-off while the sender keeps offering pairs.
	task automatic test_backpressure();
		write_size(1);
		hold_off = 1'b1;
		for (int i = 0; i < 8; i++)
			send_pair(rand_element(), rand_element());
	endtask

	// Random matrices at sizes one, two and four.
	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 20) begin
			write_size(int'($urandom_range(2)));
			n = 1 << dim_log2;
			for (int i = 0; i < n * n; i++)
				send_pair(rand_element(), rand_element());
			sent += n * n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 2'd0;
		in_valid = 1'b0;
		a_element = 16'sd0;
		b_element = 16'sd0;
		dim_log2 = 3;
		loaded = 0;
		mismatches = 0;
		checked = 0;
		matrices = 0;
		idle_enable = 1'b1;
		hold_off = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_max();
		test_directed_small();
		test_partial_drop();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
		$display("Covered %0d matrices at sizes 1 to 8, %0d product elements checked.",
			matrices, checked);
		if (mismatches == 0 && expected_products.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end
endmodule
